// ----- hdl/ordered_label_table_core_macros.svh -----
// assertion helpers
`ifndef ORDERED_LABEL_TABLE_CORE_MACROS_SVH
`define ORDERED_LABEL_TABLE_CORE_MACROS_SVH
`define OLT_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define OLT_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ----- hdl/olt_pkg.sv -----
`default_nettype none
package olt_pkg;
   localparam int Capacity = 256;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = IdxW + 1;
   localparam logic [31:0] ExtOffsetMask = 32'h00ff_ffff;
   localparam int ExtHunkShift = 24;
   localparam logic [7:0] MaxHunk = 8'd253;
   localparam logic [31:0] ReservedAddr = 32'hffff_ffff;

   typedef enum logic [3:0] {
      CMD_ENTER = 4'd0, CMD_EXT_ENTER = 4'd1, CMD_FIND = 4'd2, CMD_FIND_ACT = 4'd3,
      CMD_NEXT = 4'd4, CMD_NEXT_ACT = 4'd5, CMD_DEACT = 4'd6, CMD_COMMIT = 4'd7,
      CMD_ROLLBACK = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FULL = 2'd1, ST_HUNK = 2'd2, ST_RESERVED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_WAIT, S_RSP
   } state_type;

   typedef struct packed {
      logic named;
      logic tmpoff;
      logic is_new;
      logic active;
      logic valid;
   } flags_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] access;
      logic [15:0] name;
      flags_type   flags;
   } entry_type;
endpackage
`default_nettype wire

// ----- hdl/ordered_label_table_core.sv -----
// channel | direction | tdata                                        | tuser
// req     | in        | cmd,addr,addr_to,hunk,name_handle,access_in | has_name
// rsp     | out       | status,found,result_addr,access_out,name_out | is_new,tmp,name_valid
// Every request walks all Capacity entries through one compare unit, one entry per cycle.
// The response is registered in S_WAIT once the scan ends and held in S_RSP until rsp_tready;
// the next request is taken only after the response has been accepted.
// After reset a clearing pass writes every entry with req_tready low.
// req_tready is low while a request is in work or its response waits on rsp_tready.
`default_nettype none
`include "ordered_label_table_core_macros.svh"
module ordered_label_table_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd[3:0], addr[35:4], addr_to[67:36], hunk[75:68], name_handle[91:76], access_in[107:92]
   input  wire logic [111:0] req_tdata,
   // has_name[0]
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], found[2], result_addr[34:3], access_out[50:35], name_out[66:51]
   output logic [71:0]       rsp_tdata,
   // is_new[0], is_tmp_inactive[1], name_valid[2]
   output logic [2:0]        rsp_tuser
);
   localparam int IdxW = olt_pkg::IdxW;
   localparam int CntW = olt_pkg::CntW;

   olt_pkg::state_type state_ff, state_in;
   logic [3:0]  cmd_ff;
   logic [31:0] addr_ff, addr_to_ff, key_ff;
   logic [15:0] name_ff, acc_ff;
   logic        has_name_ff, hunk_bad_ff;
   logic [CntW-1:0] idx_ff;
   logic        hit_ff, free_ok_ff;
   logic [IdxW-1:0] hit_idx_ff, free_idx_ff;
   olt_pkg::entry_type hit_ent_ff, best_ent_ff;
   logic        pend_ff;
   logic [1:0]  st_ff;
   logic        found_ff;
   logic [31:0] raddr_ff;
   logic [15:0] racc_ff, rname_ff;
   logic        rnew_ff, rtmp_ff, rnv_ff;

   logic        wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   olt_pkg::entry_type wr_data, rd_data;

   olt_ram #(.Width($bits(olt_pkg::entry_type)), .Depth(olt_pkg::Capacity)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   wire logic [3:0]  in_cmd  = req_tdata[3:0];
   wire logic [31:0] in_addr = req_tdata[35:4];
   wire logic [7:0]  in_hunk = req_tdata[75:68];
   wire logic [31:0] ext_addr = (in_addr & olt_pkg::ExtOffsetMask) |
                                ({24'd0, in_hunk + 8'd1} << olt_pkg::ExtHunkShift);

   // scan pipeline: read issued at idx, data seen in the next cycle
   logic [CntW-1:0] rd_cnt_ff;
   logic            rd_vld_ff;
   wire logic [IdxW-1:0] cur = rd_cnt_ff[IdxW-1:0];
   olt_pkg::flags_type cf, sf, ef;
   logic is_enter, need_act, match, above, scan_wr;
   logic [CntW-1:0] done_pt;
   olt_pkg::entry_type ent, rep;
   logic [15:0] new_acc;
   logic        act_now, gain, enter_ok, rep_on, found_in;
   olt_pkg::status_type st_in;
   logic [31:0] raddr_in;

   assign cf = rd_data.flags;
   assign is_enter = (cmd_ff == olt_pkg::CMD_ENTER) || (cmd_ff == olt_pkg::CMD_EXT_ENTER);
   assign need_act = (cmd_ff == olt_pkg::CMD_FIND_ACT) || (cmd_ff == olt_pkg::CMD_NEXT_ACT);
   assign scan_wr = (cmd_ff == olt_pkg::CMD_DEACT) || (cmd_ff == olt_pkg::CMD_COMMIT) ||
                    (cmd_ff == olt_pkg::CMD_ROLLBACK);
   assign match = cf.valid && (cf.active || !need_act) && rd_data.addr == key_ff;
   assign above = cf.valid && (cf.active || !need_act) && rd_data.addr > addr_ff;
   assign done_pt = CntW'(olt_pkg::Capacity);

   assign rd_addr = idx_ff[IdxW-1:0];
   assign req_tready = state_ff == olt_pkg::S_IDLE;
   assign rsp_tvalid = state_ff == olt_pkg::S_RSP;
   assign rsp_tdata = {5'd0, rname_ff, racc_ff, raddr_ff, found_ff, st_ff};
   assign rsp_tuser = {rnv_ff, rtmp_ff, rnew_ff};

   always_comb begin
      sf = cf;
      if (cmd_ff == olt_pkg::CMD_DEACT && cf.valid && cf.active &&
          rd_data.addr >= addr_ff && rd_data.addr < addr_to_ff) begin
         sf.active = 1'b0;
         sf.tmpoff = 1'b1;
      end
      if (cmd_ff == olt_pkg::CMD_COMMIT && cf.valid) begin
         sf.is_new = 1'b0;
         sf.tmpoff = 1'b0;
      end
      if (cmd_ff == olt_pkg::CMD_ROLLBACK && cf.valid) begin
         if (cf.is_new) begin
            sf = '0;
         end else if (cf.tmpoff) begin
            sf.tmpoff = 1'b0;
            sf.active = 1'b1;
         end
      end
   end

   always_comb begin
      gain = |(acc_ff & ~hit_ent_ff.access);
      new_acc = hit_ff ? (hit_ent_ff.access | acc_ff) : acc_ff;
      act_now = !hit_ff || gain;
      ef = hit_ff ? hit_ent_ff.flags :
           '{named: has_name_ff, tmpoff: 1'b0, is_new: 1'b1, active: 1'b0, valid: 1'b1};
      ef.named = ef.named || has_name_ff;
      if (act_now && !ef.active) begin
         ef.tmpoff = 1'b0;
         ef.active = 1'b1;
      end
      ent.addr = key_ff;
      ent.access = new_acc;
      ent.name = (hit_ff && hit_ent_ff.flags.named) ? hit_ent_ff.name :
                 (has_name_ff ? name_ff : 16'd0);
      ent.flags = ef;
   end

   always_comb begin
      st_in = olt_pkg::ST_OK;
      found_in = 1'b0;
      raddr_in = 32'd0;
      rep = ent;
      rep_on = 1'b0;
      unique case (cmd_ff) inside
         olt_pkg::CMD_ENTER, olt_pkg::CMD_EXT_ENTER: begin
            if (hunk_bad_ff) begin
               st_in = olt_pkg::ST_HUNK;
            end else if (key_ff == olt_pkg::ReservedAddr) begin
               st_in = olt_pkg::ST_RESERVED;
            end else if (!hit_ff && !free_ok_ff) begin
               st_in = olt_pkg::ST_FULL;
               raddr_in = key_ff;
            end else begin
               found_in = hit_ff;
               raddr_in = key_ff;
               rep_on = 1'b1;
            end
         end
         olt_pkg::CMD_FIND, olt_pkg::CMD_FIND_ACT: begin
            raddr_in = addr_ff;
            found_in = hit_ff && addr_ff != olt_pkg::ReservedAddr;
            rep = hit_ent_ff;
            rep_on = found_in;
         end
         olt_pkg::CMD_NEXT: begin
            found_in = pend_ff && best_ent_ff.addr < addr_to_ff;
            raddr_in = found_in ? best_ent_ff.addr : addr_to_ff;
            rep = best_ent_ff;
            rep_on = found_in;
         end
         olt_pkg::CMD_NEXT_ACT: begin
            found_in = pend_ff && best_ent_ff.addr <= addr_to_ff;
            raddr_in = found_in ? best_ent_ff.addr : addr_to_ff;
            rep = best_ent_ff;
            rep_on = found_in;
         end
         default: ;
      endcase
      enter_ok = is_enter && st_in == olt_pkg::ST_OK;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur;
      wr_data = rd_data;
      wr_data.flags = sf;
      unique case (state_ff)
         olt_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff[IdxW-1:0];
            wr_data = '0;
         end
         olt_pkg::S_SCAN: wr_en = rd_vld_ff && scan_wr;
         olt_pkg::S_WAIT: begin
            wr_en = enter_ok;
            wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
            wr_data = ent;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olt_pkg::S_CLEAR: if (idx_ff == done_pt - 1'b1) begin
            state_in = olt_pkg::S_IDLE;
         end
         olt_pkg::S_IDLE: if (req_tvalid) begin
            state_in = olt_pkg::S_SCAN;
         end
         olt_pkg::S_SCAN: if (rd_vld_ff && rd_cnt_ff == done_pt - 1'b1) begin
            state_in = olt_pkg::S_WAIT;
         end
         olt_pkg::S_WAIT: state_in = olt_pkg::S_RSP;
         olt_pkg::S_RSP: if (rsp_tready) begin
            state_in = olt_pkg::S_IDLE;
         end
         default: state_in = olt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olt_pkg::S_CLEAR;
         rd_vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= state_ff == olt_pkg::S_SCAN && idx_ff < done_pt;
         if (state_ff == olt_pkg::S_IDLE) begin
            idx_ff <= '0;
         end else if (state_ff == olt_pkg::S_CLEAR ||
                      (state_ff == olt_pkg::S_SCAN && idx_ff < done_pt)) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff <= idx_ff;
      if (state_ff == olt_pkg::S_IDLE && req_tvalid) begin
         cmd_ff <= in_cmd;
         addr_ff <= in_addr;
         addr_to_ff <= req_tdata[67:36];
         name_ff <= req_tdata[91:76];
         acc_ff <= req_tdata[107:92];
         has_name_ff <= req_tuser;
         hunk_bad_ff <= in_cmd == olt_pkg::CMD_EXT_ENTER && in_hunk > olt_pkg::MaxHunk;
         key_ff <= (in_cmd == olt_pkg::CMD_EXT_ENTER) ? ext_addr : in_addr;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         pend_ff <= 1'b0;
         hit_idx_ff <= '0;
         free_idx_ff <= '0;
         hit_ent_ff <= '0;
         best_ent_ff <= '0;
      end
      if (state_ff == olt_pkg::S_SCAN && rd_vld_ff) begin
         if (match && !hit_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= cur;
            hit_ent_ff <= rd_data;
         end
         if (!cf.valid && !free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_idx_ff <= cur;
         end
         if (above && (!pend_ff || rd_data.addr < best_ent_ff.addr)) begin
            pend_ff <= 1'b1;
            best_ent_ff <= rd_data;
         end
      end
      if (state_ff == olt_pkg::S_WAIT) begin
         st_ff <= st_in;
         found_ff <= found_in;
         raddr_ff <= raddr_in;
         racc_ff <= rep_on ? rep.access : 16'd0;
         rnew_ff <= rep_on && rep.flags.is_new;
         rtmp_ff <= rep_on && rep.flags.tmpoff;
         rnv_ff <= rep_on && rep.flags.named;
         rname_ff <= (rep_on && rep.flags.named) ? rep.name : 16'd0;
      end
   end

   `OLT_ASSERT_IMP(a_busy, clock, reset, state_ff != olt_pkg::S_IDLE, !req_tready)
   `OLT_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `OLT_ASSERT_NXT(a_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `OLT_ASSERT_IMP(a_wr, clock, reset, wr_en, state_ff != olt_pkg::S_IDLE && state_ff != olt_pkg::S_RSP)
endmodule
`default_nettype wire

// ----- hdl/olt_ram.sv -----
`default_nettype none
module olt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
